@@ rtl/ps2_mouse_packet_queue_top_assert.svh @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_queue_top_assert.svh
// Assertion macros used by the mouse packet queue top level.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_QUEUE_TOP_ASSERT_SVH
`define PS2_MOUSE_PACKET_QUEUE_TOP_ASSERT_SVH

// Condition must never hold outside reset.
`define PMQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ps2mpq_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mpq_pkg
// Types, header bit positions and helpers for the mouse packet queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ps2mpq_pkg;

  // Header byte bit positions
  localparam int unsigned HdrSyncBit  = 3;
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;
  localparam int unsigned HdrXOvfBit  = 6;
  localparam int unsigned HdrYOvfBit  = 7;

  // Input beat kind, carried on tuser
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Packet assembly phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2,
    PH_SCROLL = 2'd3
  } phase_e;

  // One stored packet, buttons in the low bits
  typedef struct packed {
    logic [7:0] scroll;
    logic [7:0] y_move;
    logic [7:0] x_move;
    logic [2:0] buttons;
  } pkt_t;

  // Push request from the assembler to the queue
  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } push_t;

  // Clamp a 10-bit signed value to 8 signed bits
  function automatic logic [7:0] sat8(logic signed [9:0] v);
    logic [7:0] r;
    if (v > 10'sd127) begin
      r = 8'h7f;
    end else if (v < -10'sd128) begin
      r = 8'h80;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/ps2_mouse_packet_queue_top.sv @@
// PS/2 mouse packet queue. Mouse bytes (tuser 0) are taken one per cycle
// while the input is ready, and assembled into 3-byte packets, or 4-byte
// packets with a scroll byte in wheel mode; finished packets are stored in
// a RAM queue of QUEUE_DEPTH entries and dropped when it is full. A read
// beat (tuser 1) pops one packet and always yields one output beat, whose
// tuser says whether a packet was present. A read passes through the RAM
// read register and then the output register; the input side waits until
// that result is loaded. While a result beat is held by a stalled sink, no
// input beat of either kind is taken.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_queue_top
// Top level: input decode, wheel mode register, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2_mouse_packet_queue_top import ps2mpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: wheel mode in bit 0
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] operation
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [2:0] buttons, [10:3] x_move,
                                      // [18:11] y_move, [26:19] scroll, rest 0
  output logic        m_axis_tuser    // [0] packet_valid
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic            wheel_q;
  logic            accept;
  logic            byte_valid, rd_req;
  push_t           push;
  pkt_t            rd_data;
  logic            rd_empty;
  logic [CntW-1:0] count;
  logic            pending_q;
  logic            out_valid_q;
  logic            out_flag_q;
  pkt_t            out_pkt_q;

  // Wheel mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q <= 1'b0;
    end else if (cfg_we_i) begin
      wheel_q <= cfg_wdata_i;
    end
  end

  // Input decode; hold off while a read is in flight or the result slot is busy
  assign s_axis_tready = !pending_q && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign byte_valid    = accept && (op_e'(s_axis_tuser) == OP_BYTE);
  assign rd_req        = accept && (op_e'(s_axis_tuser) == OP_READ);

  ps2mpq_asm u_asm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_i       (s_axis_tdata),
    .wheel_mode_i (wheel_q),
    .push_o       (push)
  );

  ps2mpq_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rd_req_i   (rd_req),
    .rd_data_o  (rd_data),
    .rd_empty_o (rd_empty),
    .count_o    (count)
  );

  // Read in flight flag and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pending_q <= rd_req;
      if (pending_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload; an empty pop reads as all zeros
  always_ff @(posedge clk_i) begin
    if (pending_q) begin
      out_flag_q <= !rd_empty;
      out_pkt_q  <= rd_empty ? '0 : rd_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_flag_q;
  assign m_axis_tdata  = {5'b0, out_pkt_q};

  `include "ps2_mouse_packet_queue_top_assert.svh"

  `PMQ_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count > CntW'(QUEUE_DEPTH),
    "fill count beyond queue depth")
  `PMQ_ASSERT_NEVER(a_no_accept_pending, clk_i, rst_ni, pending_q && s_axis_tready,
    "input accepted while a read is in flight")
  `PMQ_ASSERT_NEXT(a_pending_loads, clk_i, rst_ni, pending_q, m_axis_tvalid,
    "read result not presented after RAM read")
  `PMQ_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser,
    m_axis_tdata == 32'h0, "empty pop carries nonzero payload")

endmodule

@@ rtl/ps2mpq_asm.sv @@
// ----------------------------------------------------------------------------
// ps2mpq_asm
// Collects mouse bytes into packets and formats the finished movement word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2mpq_asm import ps2mpq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  input  logic       wheel_mode_i,
  output push_t      push_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] x_q, x_d;
  logic [7:0] y_q, y_d;

  logic [7:0]        y_src;
  logic [7:0]        scroll;
  logic              ovf;
  logic signed [9:0] x10;
  logic signed [9:0] y10;
  logic              finish;

  // Phase register and captured bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hdr_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      x_q     <= x_d;
      y_q     <= y_d;
    end
  end

  // Next phase and packet completion
  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    x_d     = x_q;
    y_d     = y_q;
    finish  = 1'b0;
    scroll  = '0;
    if (byte_valid_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          // resync: only a byte with the sync bit starts a packet
          if (byte_i[HdrSyncBit]) begin
            hdr_d   = byte_i;
            phase_d = PH_X;
          end
        end
        PH_X: begin
          x_d     = byte_i;
          phase_d = PH_Y;
        end
        PH_Y: begin
          y_d = byte_i;
          if (wheel_mode_i) begin
            phase_d = PH_SCROLL;
          end else begin
            phase_d = PH_HEADER;
            finish  = 1'b1;
          end
        end
        PH_SCROLL: begin
          phase_d = PH_HEADER;
          finish  = 1'b1;
          scroll  = wheel_mode_i ? byte_i : 8'h00;
        end
        default: phase_d = PH_HEADER;
      endcase
    end
  end

  // Movement formatting: sign extend, overflow kill, negate Y, clamp
  assign y_src = (phase_q == PH_Y) ? byte_i : y_q;
  assign ovf   = hdr_q[HdrXOvfBit] | hdr_q[HdrYOvfBit];
  assign x10   = ovf ? 10'sd0
               : $signed({hdr_q[HdrXSignBit], hdr_q[HdrXSignBit], x_q});
  assign y10   = ovf ? 10'sd0
               : -$signed({hdr_q[HdrYSignBit], hdr_q[HdrYSignBit], y_src});

  assign push_o.valid          = finish;
  assign push_o.pkt.buttons    = hdr_q[2:0];
  assign push_o.pkt.x_move     = sat8(x10);
  assign push_o.pkt.y_move     = sat8(y10);
  assign push_o.pkt.scroll     = scroll;

endmodule

@@ rtl/ps2mpq_fifo.sv @@
// ----------------------------------------------------------------------------
// ps2mpq_fifo
// Packet queue on a single-port-per-direction RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2mpq_fifo import ps2mpq_pkg::*; #(
  parameter int unsigned Depth = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  push_t                          push_i,
  input  logic                           rd_req_i,
  output pkt_t                           rd_data_o,
  output logic                           rd_empty_o,
  output logic [$clog2(Depth+1)-1:0]     count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  pkt_t            mem [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  pkt_t            rdata_q;
  logic            empty_q;
  logic            do_wr, do_rd;

  // Drop when full, pop only when something is stored
  assign do_wr = push_i.valid && (count_q != CntFull);
  assign do_rd = rd_req_i && (count_q != '0);

  // Storage array: write port and registered read port
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wptr_q] <= push_i.pkt;
    end
    if (rd_req_i) begin
      rdata_q <= mem[rptr_q];
    end
  end

  // Pointers, fill count and empty flag of the last read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
      empty_q <= 1'b1;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
      if (rd_req_i) begin
        empty_q <= (count_q == '0);
      end
    end
  end

  assign rd_data_o  = rdata_q;
  assign rd_empty_o = empty_q;
  assign count_o    = count_q;

endmodule
